>>> sv/three_phase_current_profile_chopper_defines.svh
// Assertion macros shared by the chopper modules.
// The enclosing module must provide signals named clock and reset.
`ifndef THREE_PHASE_CURRENT_PROFILE_CHOPPER_DEFINES_SVH
`define THREE_PHASE_CURRENT_PROFILE_CHOPPER_DEFINES_SVH
`ifndef SYNTHESIS
`define TPCPC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define TPCPC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define TPCPC_ASSERT(lbl, prop, msg)
`define TPCPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> sv/tpcpc_pkg.sv
`default_nettype none
package tpcpc_pkg;

   localparam int TABLE_SIZE = 112;

   localparam logic [7:0]  ACTIVE_LAST     = 8'd110;
   localparam logic [7:0]  ALL_SEEN        = 8'h7E;
   localparam logic [10:0] OFFSET_CEIL     = 11'd1200;
   localparam logic [11:0] OFFSET_RAISE    = 12'd80;
   localparam logic [10:0] OFFSET_DROP     = 11'd15;
   localparam logic [10:0] OFFSET_FLOOR    = 11'd100;
   localparam logic [11:0] OFFSET_MAX      = 12'd2047;
   localparam logic [15:0] CHANGE_LIMIT    = 16'd8;
   localparam logic [15:0] CHANGE_MAX      = 16'hFFFF;
   localparam logic [3:0]  TALLY_MAX       = 4'd15;
   localparam logic        DIRECTION_RESET = 1'b1;
   localparam logic [11:0] MIN_DUTY_RESET  = 12'd30;
   localparam logic [11:0] MAX_DUTY_RESET  = 12'd2000;
   localparam logic [11:0] DUTY_RESET      = 12'd80;
   localparam logic [10:0] OFFSET_A_RESET  = 11'd250;
   localparam logic [10:0] OFFSET_BC_RESET = 11'd200;

   typedef enum logic [1:0] {
      ACTION_SENSOR = 2'd0,
      ACTION_TICK   = 2'd1,
      ACTION_SAMPLE = 2'd2,
      ACTION_IDLE   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      CSR_DIRECTION       = 3'd0,
      CSR_MIN_DUTY        = 3'd1,
      CSR_MAX_DUTY        = 3'd2,
      CSR_START_DUTY      = 3'd3,
      CSR_START_OFFSET_A  = 3'd4,
      CSR_START_OFFSET_BC = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [2:0]  active;
      logic [10:0] offset_a;
      logic [10:0] offset_bc;
   } drive_state_type;

   typedef struct packed {
      logic [2:0]  phase_enable;
      logic [11:0] drive_duty_a;
      logic [11:0] drive_duty_b;
      logic [11:0] drive_duty_c;
      logic [10:0] offset_level_a;
      logic [10:0] offset_level_bc;
   } rsp_type;

   localparam logic [8:0] PROFILE_ROM [TABLE_SIZE] = '{
      9'd7,   9'd14,  9'd22,  9'd29,  9'd37,  9'd44,  9'd51,  9'd59,
      9'd66,  9'd74,  9'd81,  9'd88,  9'd96,  9'd103, 9'd111, 9'd118,
      9'd125, 9'd133, 9'd140, 9'd148, 9'd155, 9'd162, 9'd170, 9'd177,
      9'd185, 9'd192, 9'd200, 9'd207, 9'd214, 9'd222, 9'd229, 9'd237,
      9'd244, 9'd251, 9'd259, 9'd266, 9'd274, 9'd281, 9'd288, 9'd296,
      9'd303, 9'd311, 9'd318, 9'd325, 9'd333, 9'd340, 9'd348, 9'd355,
      9'd362, 9'd370, 9'd377, 9'd385, 9'd392, 9'd400, 9'd400, 9'd392,
      9'd385, 9'd377, 9'd370, 9'd362, 9'd355, 9'd348, 9'd340, 9'd333,
      9'd325, 9'd318, 9'd311, 9'd303, 9'd296, 9'd288, 9'd281, 9'd274,
      9'd266, 9'd259, 9'd251, 9'd244, 9'd237, 9'd229, 9'd222, 9'd214,
      9'd207, 9'd200, 9'd192, 9'd185, 9'd177, 9'd170, 9'd162, 9'd155,
      9'd148, 9'd140, 9'd133, 9'd125, 9'd118, 9'd111, 9'd103, 9'd96,
      9'd88,  9'd81,  9'd74,  9'd66,  9'd59,  9'd51,  9'd44,  9'd37,
      9'd29,  9'd22,  9'd14,  9'd7,   9'd0,   9'd0,   9'd0,   9'd0
   };

   function automatic logic [8:0] profile_at(input logic [7:0] idx);
      logic [8:0] value;
      value = 9'd0;
      if (idx < 8'(TABLE_SIZE)) begin
         value = PROFILE_ROM[idx[6:0]];
      end
      return value;
   endfunction

endpackage
`default_nettype wire

>>> sv/tpcpc_lane.sv
`default_nettype none
`include "three_phase_current_profile_chopper_defines.svh"
module tpcpc_lane import tpcpc_pkg::*; #(
   parameter int         SAMPLES_PER_UPDATE = 7,
   parameter logic [3:0] COUNT_RESET        = 4'd1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step_en,
   input  logic        active,
   input  logic        prev_active,
   input  logic [8:0]  profile,
   input  logic [10:0] offset,
   input  logic [11:0] sample,
   input  logic [11:0] min_duty,
   input  logic [11:0] max_duty,
   output logic [11:0] duty_next
);

   localparam logic [3:0] UPDATE_COUNT = 4'(SAMPLES_PER_UPDATE);

   logic [11:0] base_ff, base_in;
   logic [11:0] driven_ff, driven_in;
   logic [3:0]  count_ff, count_in;
   logic [3:0]  high_ff, high_in;
   logic [3:0]  low_ff, low_in;

   logic [3:0]         count_inc;
   logic [3:0]         high_next;
   logic [3:0]         low_next;
   logic [11:0]        limit;
   logic               below;
   logic               update;
   logic signed [13:0] step_duty;
   logic signed [13:0] clamp_duty;

   always_comb begin
      base_in   = base_ff;
      driven_in = driven_ff;
      count_in  = count_ff;
      high_in   = high_ff;
      low_in    = low_ff;

      high_next = (count_ff == 4'd0) ? 4'd0 : high_ff;
      low_next  = (count_ff == 4'd0) ? 4'd0 : low_ff;
      count_inc = count_ff + 4'd1;
      limit     = {3'd0, profile} + {1'b0, offset};
      below     = sample < limit;
      update    = count_inc == UPDATE_COUNT;

      if (below) begin
         if (low_next < TALLY_MAX) begin
            low_next = low_next + 4'd1;
         end
      end else begin
         if (high_next < TALLY_MAX) begin
            high_next = high_next + 4'd1;
         end
      end

      step_duty = $signed({2'b00, base_ff});
      if (update) begin
         if (high_next < low_next) begin
            step_duty = step_duty + $signed({6'd0, profile[8:1]});
         end else begin
            step_duty = step_duty - $signed({6'd0, profile[8:1]});
         end
      end

      if (step_duty < $signed({2'b00, min_duty})) begin
         clamp_duty = $signed({2'b00, min_duty});
      end else if (step_duty > $signed({2'b00, max_duty})) begin
         clamp_duty = $signed({2'b00, max_duty});
      end else begin
         clamp_duty = step_duty;
      end

      if (step_en && active) begin
         driven_in = below ? base_ff : {2'b00, base_ff[11:2]};
         high_in   = high_next;
         low_in    = low_next;
         count_in  = update ? 4'd0 : count_inc;
         base_in   = clamp_duty[11:0];
      end else if (step_en && prev_active) begin
         count_in = 4'd0;
      end
   end

   assign duty_next = driven_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= DUTY_RESET;
         driven_ff <= DUTY_RESET;
         count_ff  <= COUNT_RESET;
         high_ff   <= 4'd0;
         low_ff    <= 4'd0;
      end else begin
         base_ff   <= base_in;
         driven_ff <= driven_in;
         count_ff  <= count_in;
         high_ff   <= high_in;
         low_ff    <= low_in;
      end
   end

   `TPCPC_ASSERT(lane_hold_inactive, step_en && !active |=> $stable(driven_ff) && $stable(base_ff), "Inactive phase changed its duty")
   `TPCPC_ASSERT(lane_count_update, step_en && active && update |=> count_ff == 4'd0, "Sample count did not restart after a duty update")

endmodule
`default_nettype wire

>>> sv/tpcpc_seq.sv
`default_nettype none
`include "three_phase_current_profile_chopper_defines.svh"
module tpcpc_seq import tpcpc_pkg::*; #(
   parameter int CYCLE_STEPS   = 162,
   parameter int PHASE_SHIFT   = 54,
   parameter int PROFILE_DEPTH = 112
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 sensor_en,
   input  logic                 tick_en,
   input  logic [2:0]           sensor_code,
   input  logic                 direction,
   output drive_state_type      state_now,
   output drive_state_type      state_next,
   output logic [2:0][8:0]      profile
);

   localparam int SHIFT_ONE = PHASE_SHIFT % CYCLE_STEPS;
   localparam int SHIFT_TWO = (2 * PHASE_SHIFT) % CYCLE_STEPS;

   logic [7:0]       pos_ff, pos_in;
   logic [2:0]       active_ff, active_in;
   logic [2:0][8:0]  profile_ff, profile_in;
   logic [10:0]      offset_a_ff, offset_a_in;
   logic [10:0]      offset_bc_ff, offset_bc_in;
   logic [2:0]       last_ff, last_in;
   logic [15:0]      change_ff, change_in;
   logic [7:0]       seen_ff, seen_in;

   logic [8:0]       sum_one, sum_two, pos_inc;
   logic [7:0]       pos_one, pos_two;
   logic [2:0][7:0]  visit_pos;
   logic             wrap;
   logic [11:0]      raise_a, raise_bc;
   logic [10:0]      up_a, up_bc, down_a, down_bc;

   always_comb begin
      pos_in       = pos_ff;
      active_in    = active_ff;
      profile_in   = profile_ff;
      offset_a_in  = offset_a_ff;
      offset_bc_in = offset_bc_ff;
      last_in      = last_ff;
      change_in    = change_ff;
      seen_in      = seen_ff;

      sum_one = {1'b0, pos_ff} + 9'(SHIFT_ONE);
      sum_two = {1'b0, pos_ff} + 9'(SHIFT_TWO);
      pos_one = (sum_one >= 9'(CYCLE_STEPS)) ? 8'(sum_one - 9'(CYCLE_STEPS)) : sum_one[7:0];
      pos_two = (sum_two >= 9'(CYCLE_STEPS)) ? 8'(sum_two - 9'(CYCLE_STEPS)) : sum_two[7:0];
      visit_pos[0] = pos_ff;
      visit_pos[1] = direction ? pos_one : pos_two;
      visit_pos[2] = direction ? pos_two : pos_one;
      pos_inc = {1'b0, pos_ff} + 9'd1;
      wrap    = pos_inc == 9'(CYCLE_STEPS);

      raise_a  = {1'b0, offset_a_ff} + OFFSET_RAISE;
      raise_bc = {1'b0, offset_bc_ff} + OFFSET_RAISE;
      up_a  = offset_a_ff;
      up_bc = offset_bc_ff;
      if (seen_ff != ALL_SEEN && offset_a_ff < OFFSET_CEIL) begin
         up_a  = (raise_a > OFFSET_MAX) ? OFFSET_MAX[10:0] : raise_a[10:0];
         up_bc = (raise_bc > OFFSET_MAX) ? OFFSET_MAX[10:0] : raise_bc[10:0];
      end
      down_a  = up_a;
      down_bc = up_bc;
      if (change_ff > CHANGE_LIMIT && up_a > OFFSET_FLOOR) begin
         down_a  = (up_a < OFFSET_DROP) ? 11'd0 : up_a - OFFSET_DROP;
         down_bc = (up_bc < OFFSET_DROP) ? 11'd0 : up_bc - OFFSET_DROP;
      end

      if (sensor_en && sensor_code != last_ff) begin
         if (change_ff < CHANGE_MAX) begin
            change_in = change_ff + 16'd1;
         end
         seen_in = seen_ff | (8'd1 << sensor_code);
         last_in = sensor_code;
      end

      if (tick_en) begin
         for (int i = 0; i < 3; i++) begin
            active_in[i] = visit_pos[i] <= ACTIVE_LAST;
            if (visit_pos[i] <= ACTIVE_LAST) begin
               profile_in[i] = (visit_pos[i] < 8'(PROFILE_DEPTH)) ?
                               profile_at(visit_pos[i]) : 9'd0;
            end
         end
         pos_in = wrap ? 8'd0 : pos_inc[7:0];
         if (wrap) begin
            offset_a_in  = down_a;
            offset_bc_in = down_bc;
            seen_in      = 8'd0;
            change_in    = 16'd0;
         end
      end
   end

   always_comb begin
      state_now.active     = active_ff;
      state_now.offset_a   = offset_a_ff;
      state_now.offset_bc  = offset_bc_ff;
      state_next.active    = active_in;
      state_next.offset_a  = offset_a_in;
      state_next.offset_bc = offset_bc_in;
      profile              = profile_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 8'd0;
         active_ff    <= 3'b111;
         profile_ff   <= '0;
         offset_a_ff  <= OFFSET_A_RESET;
         offset_bc_ff <= OFFSET_BC_RESET;
         last_ff      <= 3'd0;
         change_ff    <= 16'd0;
         seen_ff      <= 8'd0;
      end else begin
         pos_ff       <= pos_in;
         active_ff    <= active_in;
         profile_ff   <= profile_in;
         offset_a_ff  <= offset_a_in;
         offset_bc_ff <= offset_bc_in;
         last_ff      <= last_in;
         change_ff    <= change_in;
         seen_ff      <= seen_in;
      end
   end

   `TPCPC_ASSERT(seq_pos_range, pos_ff < 8'(CYCLE_STEPS), "Cycle position left its range")
   `TPCPC_ASSERT(seq_wrap_clear, tick_en && wrap |=> seen_ff == 8'd0 && change_ff == 16'd0 && pos_ff == 8'd0, "Cycle wrap did not clear the sensor activity")

endmodule
`default_nettype wire

>>> sv/tpcpc_outbuf.sv
`default_nettype none
`include "three_phase_current_profile_chopper_defines.svh"
module tpcpc_outbuf import tpcpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_item,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_item
);

   logic [1:0] count_ff, count_in;
   rsp_type    head_ff, head_in;
   rsp_type    tail_ff, tail_in;
   logic       push;
   logic       pop;

   assign in_ready  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_item  = head_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      case (count_ff)
         2'd0: begin
            if (push) begin
               head_in = in_item;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = in_item;
            end else if (push) begin
               tail_in = in_item;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in = tail_ff;
            end
         end
         default: begin
            count_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   `TPCPC_ASSERT(outbuf_full_hold, count_ff == 2'd2 && !pop |=> count_ff == 2'd2 && $stable(head_ff), "Full output buffer lost or changed a result")
   `TPCPC_ASSERT(outbuf_count_range, count_ff != 2'd3, "Output buffer count out of range")

endmodule
`default_nettype wire

>>> sv/three_phase_current_profile_chopper.sv
`default_nettype none
// Three-phase current-profile chopper. Each accepted request is a sensor reading, a control
// tick, a current sample tick or an idle request, and each one yields exactly one response
// carrying the phase enables, the duty driven on each phase and the two current offsets as they
// stand after that request. One request is taken every clock while req_ready is high: the three
// phase lanes and the position sequencer finish their update in the cycle of the transfer, and
// the response is registered into a two-entry output buffer, so req_ready drops only while both
// buffer entries hold responses that have not been taken. Configuration writes complete in every
// cycle. Writes to the start duty and start offset indices are accepted but change nothing, and
// the duties and offsets load their reset defaults at reset.
`include "three_phase_current_profile_chopper_defines.svh"
module three_phase_current_profile_chopper import tpcpc_pkg::*; #(
   parameter int CYCLE_STEPS        = 162,
   parameter int PHASE_SHIFT        = 54,
   parameter int PROFILE_DEPTH      = 112,
   parameter int SAMPLES_PER_UPDATE = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [2:0]  req_sensor_code,
   input  logic [11:0] req_current_a,
   input  logic [11:0] req_current_b,
   input  logic [11:0] req_current_c,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_phase_enable,
   output logic [11:0] rsp_drive_duty_a,
   output logic [11:0] rsp_drive_duty_b,
   output logic [11:0] rsp_drive_duty_c,
   output logic [10:0] rsp_offset_level_a,
   output logic [10:0] rsp_offset_level_bc,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data
);

   logic        direction_ff, direction_in;
   logic [11:0] min_duty_ff, min_duty_in;
   logic [11:0] max_duty_ff, max_duty_in;

   logic             accept;
   logic             sensor_en;
   logic             tick_en;
   logic             sample_en;
   drive_state_type  state_now;
   drive_state_type  state_next;
   logic [2:0][8:0]  profile;
   logic [2:0][11:0] sample;
   logic [2:0][11:0] duty_next;
   rsp_type          rsp_item;
   rsp_type          rsp_out;

   assign csr_ready = 1'b1;

   always_comb begin
      direction_in = direction_ff;
      min_duty_in  = min_duty_ff;
      max_duty_in  = max_duty_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DIRECTION: begin
               direction_in = csr_data[0];
            end
            CSR_MIN_DUTY: begin
               min_duty_in = csr_data;
            end
            CSR_MAX_DUTY: begin
               max_duty_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIRECTION_RESET;
         min_duty_ff  <= MIN_DUTY_RESET;
         max_duty_ff  <= MAX_DUTY_RESET;
      end else begin
         direction_ff <= direction_in;
         min_duty_ff  <= min_duty_in;
         max_duty_ff  <= max_duty_in;
      end
   end

   assign accept    = req_valid && req_ready;
   assign sensor_en = accept && (req_action == ACTION_SENSOR);
   assign tick_en   = accept && (req_action == ACTION_TICK);
   assign sample_en = accept && (req_action == ACTION_SAMPLE);

   tpcpc_seq #(
      .CYCLE_STEPS   (CYCLE_STEPS),
      .PHASE_SHIFT   (PHASE_SHIFT),
      .PROFILE_DEPTH (PROFILE_DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .sensor_en   (sensor_en),
      .tick_en     (tick_en),
      .sensor_code (req_sensor_code),
      .direction   (direction_ff),
      .state_now   (state_now),
      .state_next  (state_next),
      .profile     (profile)
   );

   assign sample[0] = req_current_a;
   assign sample[1] = req_current_b;
   assign sample[2] = req_current_c;

   for (genvar j = 0; j < 3; j++) begin : g_lane
      tpcpc_lane #(
         .SAMPLES_PER_UPDATE (SAMPLES_PER_UPDATE),
         .COUNT_RESET        (4'(j + 1))
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .step_en     (sample_en),
         .active      (state_now.active[j]),
         .prev_active (state_now.active[(j + 2) % 3]),
         .profile     (profile[j]),
         .offset      ((j == 0) ? state_now.offset_a : state_now.offset_bc),
         .sample      (sample[j]),
         .min_duty    (min_duty_ff),
         .max_duty    (max_duty_ff),
         .duty_next   (duty_next[j])
      );
   end

   always_comb begin
      rsp_item.phase_enable    = state_next.active;
      rsp_item.drive_duty_a    = duty_next[0];
      rsp_item.drive_duty_b    = duty_next[1];
      rsp_item.drive_duty_c    = duty_next[2];
      rsp_item.offset_level_a  = state_next.offset_a;
      rsp_item.offset_level_bc = state_next.offset_bc;
   end

   tpcpc_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (rsp_item),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_out)
   );

   assign rsp_phase_enable    = rsp_out.phase_enable;
   assign rsp_drive_duty_a    = rsp_out.drive_duty_a;
   assign rsp_drive_duty_b    = rsp_out.drive_duty_b;
   assign rsp_drive_duty_c    = rsp_out.drive_duty_c;
   assign rsp_offset_level_a  = rsp_out.offset_level_a;
   assign rsp_offset_level_bc = rsp_out.offset_level_bc;

endmodule
`default_nettype wire
